FILE: hw/rtl/fird_pkg.sv
// fir decimator package: shared widths, the low-pass coefficient table and control types
// no dependencies; used by every module of the fir decimator
`timescale 1ns / 1ps
`default_nettype none

package fird_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int COEF_W        = 16;
    localparam int PROD_W        = SAMPLE_W + COEF_W;
    localparam int FRAC_BITS     = 15;
    localparam int RATIO_W       = 5;
    localparam int PHASE_W       = 4;
    localparam int RATIO_MAX     = 16;
    localparam int COEF_LEN      = 32;
    localparam int TAP_IDX_W     = 7;
    localparam int TAP_COUNT_DEF = 32;

    // q15 low-pass coefficients, index 0 weighs the oldest sample
    localparam logic signed [COEF_W-1:0] LP_COEF [COEF_LEN] = '{
            16'sd1,     16'sd7,     16'sd4,   -16'sd33,
          -16'sd88,   -16'sd61,   16'sd146,   16'sd415,
           16'sd350,  -16'sd357, -16'sd1335, -16'sd1407,
           16'sd583,  16'sd4507,  16'sd8528, 16'sd10238,
          16'sd8528,  16'sd4507,   16'sd583, -16'sd1407,
         -16'sd1335,  -16'sd357,   16'sd350,   16'sd415,
           16'sd146,   -16'sd61,   -16'sd88,   -16'sd33,
             16'sd4,     16'sd7,     16'sd1,     16'sd0
    };

    // coefficient for a tap position; taps past the table weigh zero
    function automatic logic signed [COEF_W-1:0] coef_at(input logic [TAP_IDX_W-1:0] t);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (t < TAP_IDX_W'(COEF_LEN)) begin
            c = LP_COEF[t[4:0]];
        end
        return c;
    endfunction

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;   // start a new sum
        logic mul_en;  // a tap product is formed this cycle
    } mac_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fird_cell.sv
// fir decimator history cell: holds one sample and passes it to the next cell on shift
// depends on fird_pkg
`timescale 1ns / 1ps
`default_nettype none

module fird_cell (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 shift_en,
    input  wire logic signed [fird_pkg::SAMPLE_W-1:0] din,
    output logic signed [fird_pkg::SAMPLE_W-1:0]      dout
);

    logic signed [fird_pkg::SAMPLE_W-1:0] data_reg;

    // history is cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= '0;
        end else if (shift_en) begin
            data_reg <= din;
        end
    end

    assign dout = data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/fird_mac.sv
// fir decimator multiply-accumulate unit with q15 truncation and 16-bit saturation
// depends on fird_pkg
`timescale 1ns / 1ps
`default_nettype none

module fird_mac #(
    parameter int TAP_COUNT = fird_pkg::TAP_COUNT_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire fird_pkg::mac_ctrl_t                  ctrl,
    input  wire logic signed [fird_pkg::SAMPLE_W-1:0] sample,
    input  wire logic signed [fird_pkg::COEF_W-1:0]   coef,
    output logic signed [fird_pkg::SAMPLE_W-1:0]      result
);

    localparam int PW    = fird_pkg::PROD_W;
    localparam int ACC_W = PW + $clog2(TAP_COUNT) + 1;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(32768));
    localparam logic signed [ACC_W-1:0] BIAS   = ACC_W'((1 << fird_pkg::FRAC_BITS) - 1);

    logic signed [PW-1:0]    prod_reg;
    logic                    acc_en_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] biased;
    logic signed [ACC_W-1:0] quot;

    // product stage
    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= sample * coef;
        end
    end

    // accumulate the product in the cycle after it is formed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_en_reg <= 1'b0;
        end else begin
            acc_en_reg <= ctrl.mul_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (acc_en_reg) begin
            acc_reg <= acc_reg + {{(ACC_W-PW){prod_reg[PW-1]}}, prod_reg};
        end
    end

    // shift right truncating toward zero, then saturate
    always_comb begin
        biased = acc_reg + (acc_reg[ACC_W-1] ? BIAS : '0);
        quot   = biased >>> fird_pkg::FRAC_BITS;
        if (quot > SAT_HI) begin
            result = SAT_HI[fird_pkg::SAMPLE_W-1:0];
        end else if (quot < SAT_LO) begin
            result = SAT_LO[fird_pkg::SAMPLE_W-1:0];
        end else begin
            result = quot[fird_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fir_decimator_32tap.sv
// fir decimator top level: history cell chain, tap sequencer, ratio and phase control
// depends on fird_pkg, fird_cell and fird_mac
`timescale 1ns / 1ps
`default_nettype none
//
// Decimating low-pass FIR filter on signed 16-bit audio samples.
// Input samples arrive on the s_ stream channel, filtered results leave on the m_ channel.
// The decimation ratio is written on the cfg channel (always ready); the user must write it
// only while the block is idle, as nothing in the block enforces this. Zero acts as 1,
// values above 16 act as 16. Ratio 1 passes each sample through without touching the history.
// Samples are held in a chain of TAP_COUNT cells, newest at the head. A sample that does not
// complete a decimation phase is taken into the history while the block stays idle. A sample
// that completes the phase starts a walk of the chain: the chain rotates once around while a
// single multiplier of the shared multiply-accumulate unit weighs the tail cell; the sum then
// passes the drain and finish states into the output register, finish waiting while a pending
// result is still held, and the next sample is taken once the block is back in idle.
// Passthrough results are registered and appear in the cycle after their input transaction.
// Reset clears the history, the phase and the output valid, and sets the ratio to 1.
// When the receiver stalls, the finished result is held in the output register; the block
// keeps taking samples that produce no result and waits before overwriting a pending one.
//
module fir_decimator_32tap #(
    parameter int TAP_COUNT = fird_pkg::TAP_COUNT_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input samples
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [fird_pkg::SAMPLE_W-1:0]        s_tdata,   // [15:0] sample
    // filtered results
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [fird_pkg::SAMPLE_W-1:0]             m_tdata,   // [15:0] filtered_sample
    // ratio register write
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [fird_pkg::RATIO_W-1:0]         cfg_data   // [4:0] decim_ratio
);

    localparam int SW = fird_pkg::SAMPLE_W;
    localparam int TW = $clog2(TAP_COUNT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                          state_reg;
    logic [fird_pkg::RATIO_W-1:0]    ratio_reg;
    logic [fird_pkg::PHASE_W-1:0]    phase_reg;
    logic [TW-1:0]                   tap_reg;
    logic                            m_tvalid_reg;
    logic [SW-1:0]                   m_tdata_reg;

    logic [fird_pkg::RATIO_W-1:0]    ratio_eff;
    logic [fird_pkg::RATIO_W-1:0]    phase_next;
    logic                            passthru;
    logic                            out_free;
    logic                            accept;
    logic                            hist_take;
    logic                            phase_done;
    logic                            rotate;
    logic signed [SW-1:0]            chain_in;
    logic signed [SW-1:0]            tap_q [TAP_COUNT];
    logic signed [SW-1:0]            tail;
    logic signed [fird_pkg::COEF_W-1:0] coef;
    logic signed [SW-1:0]            mac_result;
    fird_pkg::mac_ctrl_t             mac_ctrl;

    // effective ratio: zero acts as one, above max clamps
    always_comb begin
        if (ratio_reg == '0) begin
            ratio_eff = fird_pkg::RATIO_W'(1);
        end else if (ratio_reg > fird_pkg::RATIO_W'(fird_pkg::RATIO_MAX)) begin
            ratio_eff = fird_pkg::RATIO_W'(fird_pkg::RATIO_MAX);
        end else begin
            ratio_eff = ratio_reg;
        end
    end

    // handshake and phase decode
    assign passthru   = (ratio_eff == fird_pkg::RATIO_W'(1));
    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE) && (!passthru || out_free);
    assign accept     = s_tvalid && s_tready;
    assign hist_take  = accept && !passthru;
    assign phase_next = {1'b0, phase_reg} + fird_pkg::RATIO_W'(1);
    assign phase_done = phase_next >= ratio_eff;
    assign rotate     = (state_reg == ST_MAC);
    assign cfg_ready  = 1'b1;

    // chain of history cells: new sample enters at the head, the walk feeds the tail back
    assign tail     = tap_q[TAP_COUNT-1];
    assign chain_in = rotate ? tail : $signed(s_tdata);

    genvar k;
    generate
        for (k = 0; k < TAP_COUNT; k++) begin : g_cell
            if (k == 0) begin : g_head
                fird_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (hist_take || rotate),
                    .din      (chain_in),
                    .dout     (tap_q[k])
                );
            end else begin : g_body
                fird_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (hist_take || rotate),
                    .din      (tap_q[k-1]),
                    .dout     (tap_q[k])
                );
            end
        end
    endgenerate

    // shared multiply-accumulate, tail cell holds the oldest sample first
    assign coef            = fird_pkg::coef_at(fird_pkg::TAP_IDX_W'(tap_reg));
    assign mac_ctrl.clear  = hist_take && phase_done;
    assign mac_ctrl.mul_en = rotate;

    fird_mac #(
        .TAP_COUNT (TAP_COUNT)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .sample  (tail),
        .coef    (coef),
        .result  (mac_result)
    );

    // sequencer, ratio register, phase counter and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ratio_reg    <= fird_pkg::RATIO_W'(1);
            phase_reg    <= '0;
            tap_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                ratio_reg <= cfg_data;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && passthru) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= s_tdata;
                    end else if (hist_take) begin
                        if (phase_done) begin
                            phase_reg <= '0;
                            tap_reg   <= '0;
                            state_reg <= ST_MAC;
                        end else begin
                            phase_reg <= phase_next[fird_pkg::PHASE_W-1:0];
                        end
                    end
                end
                ST_MAC: begin
                    tap_reg <= tap_reg + TW'(1);
                    if (tap_reg == TW'(TAP_COUNT - 1)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= mac_result;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
